// ----- rtl/scfd_pkg.sv -----
// scfd_pkg: shared types and constants of the command frame decoder
// no dependencies; used by every module under rtl
package scfd_pkg;

    localparam int unsigned ADDR_W  = 24;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned REG_W   = 7;
    localparam int unsigned SPACE_W = 3;

    localparam logic [7:0] OP_TRANSFER = 8'h7F;

    // bit positions of the transfer sub0 byte
    localparam int unsigned SUB0_DIR_BIT   = 0;
    localparam int unsigned SUB0_SPACE_LSB = 1;
    localparam int unsigned SUB0_INC_BIT   = 4;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_REGVAL = 4'd1,
        PH_SUB0   = 4'd2,
        PH_ADDR0  = 4'd3,
        PH_ADDR1  = 4'd4,
        PH_ADDR2  = 4'd5,
        PH_LEN0   = 4'd6,
        PH_LEN1   = 4'd7,
        PH_DUMMY  = 4'd8,
        PH_DATA   = 4'd9,
        PH_DONE   = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_REG_READ  = 3'd1,
        KIND_REG_WRITE = 3'd2,
        KIND_MEM_READ  = 3'd3,
        KIND_MEM_WRITE = 3'd4
    } access_kind_t;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        access_kind_t       kind;
        logic [SPACE_W-1:0] space;
        logic [ADDR_W-1:0]  address;
        logic [7:0]         wval;
        logic               last;
    } result_t;

endpackage

// ----- rtl/scfd_in_stage.sv -----
// scfd_in_stage: input register holding one received word
// depends on scfd_pkg
module scfd_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  scfd_pkg::in_word_t in_word,
    output logic              s1_valid,
    input  logic              s1_ready,
    output scfd_pkg::in_word_t s1_word
);

    logic               valid_reg;
    logic               valid_next;
    scfd_pkg::in_word_t word_reg;

    assign in_ready = !valid_reg || s1_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_word  = word_reg;

endmodule

// ----- rtl/scfd_decode.sv -----
// scfd_decode: frame phase machine and transfer context, one word per step
// depends on scfd_pkg
module scfd_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  scfd_pkg::in_word_t word,
    output scfd_pkg::result_t  res
);

    scfd_pkg::phase_t                 phase_reg, phase_next;
    logic [scfd_pkg::REG_W-1:0]       reg_index_reg, reg_index_next;
    logic [scfd_pkg::SPACE_W-1:0]     space_reg, space_next;
    logic                             is_read_reg, is_read_next;
    logic                             incr_reg, incr_next;
    logic [scfd_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [scfd_pkg::LEN_W-1:0]       left_reg, left_next;

    logic [7:0] b;
    logic       data_hit;

    assign b        = word.rx_byte;
    assign data_hit = !word.frame_start && (phase_reg == scfd_pkg::PH_DATA) && (left_reg != '0);

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        reg_index_next = reg_index_reg;
        space_next     = space_reg;
        is_read_next   = is_read_reg;
        incr_next      = incr_reg;
        addr_next      = addr_reg;
        left_next      = left_reg;
        if (word.frame_start)
        begin
            if (b[7])
            begin
                reg_index_next = b[scfd_pkg::REG_W-1:0];
                phase_next     = scfd_pkg::PH_DONE;
            end
            else if (b == scfd_pkg::OP_TRANSFER)
            begin
                phase_next = scfd_pkg::PH_SUB0;
            end
            else
            begin
                reg_index_next = b[scfd_pkg::REG_W-1:0];
                phase_next     = scfd_pkg::PH_REGVAL;
            end
        end
        else
        begin
            case (phase_reg)
                scfd_pkg::PH_REGVAL:
                begin
                    phase_next = scfd_pkg::PH_DONE;
                end
                scfd_pkg::PH_SUB0:
                begin
                    is_read_next = b[scfd_pkg::SUB0_DIR_BIT];
                    space_next   = b[scfd_pkg::SUB0_SPACE_LSB +: scfd_pkg::SPACE_W];
                    incr_next    = b[scfd_pkg::SUB0_INC_BIT];
                    phase_next   = scfd_pkg::PH_ADDR0;
                end
                scfd_pkg::PH_ADDR0:
                begin
                    addr_next[7:0] = b;
                    phase_next     = scfd_pkg::PH_ADDR1;
                end
                scfd_pkg::PH_ADDR1:
                begin
                    addr_next[15:8] = b;
                    phase_next      = scfd_pkg::PH_ADDR2;
                end
                scfd_pkg::PH_ADDR2:
                begin
                    addr_next[23:16] = b;
                    phase_next       = scfd_pkg::PH_LEN0;
                end
                scfd_pkg::PH_LEN0:
                begin
                    left_next[7:0] = b;
                    phase_next     = scfd_pkg::PH_LEN1;
                end
                scfd_pkg::PH_LEN1:
                begin
                    left_next[15:8] = b;
                    phase_next      = is_read_reg ? scfd_pkg::PH_DUMMY : scfd_pkg::PH_DATA;
                end
                scfd_pkg::PH_DUMMY:
                begin
                    phase_next = scfd_pkg::PH_DATA;
                end
                scfd_pkg::PH_DATA:
                begin
                    if (left_reg != '0)
                    begin
                        left_next = left_reg - scfd_pkg::LEN_W'(1);
                        if (incr_reg)
                        begin
                            // 24-bit sum wraps on its own
                            addr_next = addr_reg + scfd_pkg::ADDR_W'(1);
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result of the current word
    always_comb
    begin
        res = '{kind: scfd_pkg::KIND_NONE, space: '0, address: '0, wval: '0, last: 1'b0};
        if (word.frame_start)
        begin
            if (b[7])
            begin
                res.kind    = scfd_pkg::KIND_REG_READ;
                res.address = scfd_pkg::ADDR_W'(b[scfd_pkg::REG_W-1:0]);
            end
        end
        else if (phase_reg == scfd_pkg::PH_REGVAL)
        begin
            res.kind    = scfd_pkg::KIND_REG_WRITE;
            res.address = scfd_pkg::ADDR_W'(reg_index_reg);
            res.wval    = b;
        end
        else if (data_hit)
        begin
            res.kind    = is_read_reg ? scfd_pkg::KIND_MEM_READ : scfd_pkg::KIND_MEM_WRITE;
            res.space   = space_reg;
            res.address = addr_reg;
            res.wval    = is_read_reg ? 8'h00 : b;
            res.last    = (left_reg == scfd_pkg::LEN_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= scfd_pkg::PH_IDLE;
            reg_index_reg <= '0;
            space_reg     <= '0;
            is_read_reg   <= 1'b0;
            incr_reg      <= 1'b0;
            addr_reg      <= '0;
            left_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            reg_index_reg <= reg_index_next;
            space_reg     <= space_next;
            is_read_reg   <= is_read_next;
            incr_reg      <= incr_next;
            addr_reg      <= addr_next;
            left_reg      <= left_next;
        end
    end

    // a memory access consumes exactly one count
    assert property (@(posedge clk) disable iff (!rst_n)
        step && data_hit |=> left_reg == $past(left_reg) - scfd_pkg::LEN_W'(1))
        else $error("byte count did not step on a data access");

    // memory accesses only come out of the data phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.kind == scfd_pkg::KIND_MEM_READ || res.kind == scfd_pkg::KIND_MEM_WRITE)
        |-> phase_reg == scfd_pkg::PH_DATA && !word.frame_start)
        else $error("memory access outside data phase");

    // count never moves outside the length and data phases
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !word.frame_start && phase_reg != scfd_pkg::PH_DATA
        && phase_reg != scfd_pkg::PH_LEN0 && phase_reg != scfd_pkg::PH_LEN1
        |=> $stable(left_reg))
        else $error("byte count changed outside its phases");

endmodule

// ----- rtl/scfd_out_stage.sv -----
// scfd_out_stage: result register with valid/ready toward the consumer
// depends on scfd_pkg
module scfd_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    output logic              load_ready,
    input  scfd_pkg::result_t res,
    output logic              out_valid,
    input  logic              out_ready,
    output scfd_pkg::result_t out_res
);

    logic              valid_reg;
    logic              valid_next;
    scfd_pkg::result_t res_reg;

    assign load_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ready)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_ready)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- rtl/spi_command_frame_decoder.sv -----
// spi_command_frame_decoder: target-side decoder of chip-select-framed commands
// path: word registered in scfd_in_stage, decoded combinationally, result registered in scfd_out_stage
// throughput: one word per cycle while out_ready stays high; every word gives exactly one result word
// reset: rst_n async active low; frame phase idle, transfer context zero, both stages empty
// depends on scfd_pkg, scfd_in_stage, scfd_decode, scfd_out_stage
module spi_command_frame_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        frame_start,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  access_kind,
    output logic [2:0]  access_space,
    output logic [23:0] access_address,
    output logic [7:0]  write_value,
    output logic        transfer_last
);

    scfd_pkg::in_word_t in_word;
    scfd_pkg::in_word_t s1_word;
    scfd_pkg::result_t  res;
    scfd_pkg::result_t  out_res;
    logic               s1_valid;
    logic               s1_ready;
    logic               step;

    assign in_word.frame_start = frame_start;
    assign in_word.rx_byte     = rx_byte;

    scfd_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_word  (s1_word)
    );

    assign step = s1_valid && s1_ready;

    scfd_decode u_dec
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .word  (s1_word),
        .res   (res)
    );

    scfd_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_valid),
        .load_ready (s1_ready),
        .res        (res),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res)
    );

    assign access_kind    = out_res.kind;
    assign access_space   = out_res.space;
    assign access_address = out_res.address;
    assign write_value    = out_res.wval;
    assign transfer_last  = out_res.last;

endmodule
